>>> src/bb3_pkg.sv
// Shared constants, command and register codes, and the reciprocal table
// for the 3x3 RGB box blur. No dependencies.
package bb3_pkg;

  // Field and counter widths fixed by the stream format.
  localparam int PIX_W = 24;
  localparam int ROW_W = 13;
  localparam int WIDTH_FIELD_W = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  // Defaults and limits.
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int RESET_WIDTH = 640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam int QUEUE_DEPTH = 4;

  // Command codes of an input word.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Mean arithmetic: sums of up to nine bytes, divided via a reciprocal.
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W = 21;

  // Rounded-up reciprocal of a neighbor count, scaled by 2^RECIP_SHIFT.
  // The scale leaves the quotient exact for every sum below 4096.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    unique case (cnt)
      4'd1:    m = 21'd1048576;
      4'd2:    m = 21'd524288;
      4'd3:    m = 21'd349526;
      4'd4:    m = 21'd262144;
      4'd6:    m = 21'd174763;
      4'd9:    m = 21'd116509;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

endpackage

>>> src/bb3_pix_if.sv
// Input channel of the box blur: pixel or flush words.
// Depends on nothing.
interface bb3_pix_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, command, red, green, blue, input ready);
  modport sink(input valid, command, red, green, blue, output ready);
endinterface

>>> src/bb3_res_if.sv
// Result channel of the box blur: blurred pixels with an end-of-frame mark.
// Depends on nothing.
interface bb3_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] blur_red;
  logic [7:0] blur_green;
  logic [7:0] blur_blue;
  logic       end_of_frame;

  modport source(output valid, blur_red, blur_green, blur_blue, end_of_frame, input ready);
  modport sink(input valid, blur_red, blur_green, blur_blue, end_of_frame, output ready);
endinterface

>>> src/bb3_cfg_if.sv
// Register write channel of the box blur.
// Depends on bb3_pkg for the index and data widths.
interface bb3_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bb3_pkg::CFG_IDX_W-1:0]   index;
  logic [bb3_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/bb3_queue.sv
// Small first-in first-out queue of slot words between front and back.
// Depends on bb3_pkg only for the default depth.
module bb3_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bb3_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  fill;

  assign full     = (fill == CntW'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth; the fill count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end
endmodule

>>> src/bb3_front.sv
// Front end of the box blur: accepts words, tracks the raster position and
// turns pixels and flushes into slots for the back end. Depends on bb3_pkg.
module bb3_front #(
  parameter int MAX_WIDTH = bb3_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic clk,
  input  logic rst,
  bb3_pix_if.sink pix,
  input  logic restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] image_width,
  input  logic [bb3_pkg::HEIGHT_W-1:0] image_height,
  input  logic q_full,
  output logic push,
  output logic [bb3_pkg::PIX_W+$clog2(MAX_WIDTH)+bb3_pkg::ROW_W-1:0] push_data
);
  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int RowW = bb3_pkg::ROW_W;

  logic [ColW-1:0] col, col_next, pos_col;
  logic [RowW-1:0] row, row_next, pos_row;
  logic follow, follow_next;
  logic drain, accept, slot_go, at_eof;
  logic [bb3_pkg::PIX_W-1:0] slot_pix;
  logic [WB-1:0] col_inc;

  // A flush at the first column of a one-row frame's drain row releases
  // nothing by itself, so a second drain slot follows it.
  assign pix.ready = !q_full && !follow;
  assign accept    = pix.valid && pix.ready;
  assign drain     = (row >= image_height);

  // Slot selection and position advance.
  always_comb begin
    slot_go     = 1'b0;
    pos_col     = col;
    pos_row     = row;
    slot_pix    = '0;
    follow_next = follow;
    priority if (follow) begin
      slot_go = !q_full;
      if (!q_full) begin
        follow_next = 1'b0;
      end
    end else if (accept && pix.command == bb3_pkg::CMD_PIXEL) begin
      slot_go  = 1'b1;
      slot_pix = {pix.red, pix.green, pix.blue};
      if (drain) begin
        pos_col = '0;
        pos_row = '0;
      end
    end else if (accept && drain) begin
      slot_go = 1'b1;
      if (col == '0 && row < RowW'(2)) begin
        follow_next = 1'b1;
      end
    end else begin
      slot_go = 1'b0;
    end

    at_eof   = (pos_col == '0) && (pos_row == image_height + RowW'(1));
    col_inc  = WB'(pos_col) + WB'(1);
    col_next = col;
    row_next = row;
    if (slot_go) begin
      if (at_eof) begin
        col_next = '0;
        row_next = '0;
      end else if (col_inc == image_width) begin
        col_next = '0;
        row_next = pos_row + RowW'(1);
      end else begin
        col_next = pos_col + ColW'(1);
        row_next = pos_row;
      end
    end
  end

  assign push      = slot_go;
  assign push_data = {slot_pix, pos_col, pos_row};

  // Position registers; a register write returns to the start of a frame.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col    <= '0;
      row    <= '0;
      follow <= 1'b0;
    end else begin
      col    <= col_next;
      row    <= row_next;
      follow <= follow_next;
    end
  end
endmodule

>>> src/bb3_back.sv
// Back end of the box blur: line buffers, 3x3 window, neighbor sums and the
// rounded division, with a registered result word. Depends on bb3_pkg.
module bb3_back #(
  parameter int MAX_WIDTH = bb3_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic pop,
  input  logic [bb3_pkg::PIX_W+$clog2(MAX_WIDTH)+bb3_pkg::ROW_W-1:0] pop_data,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] image_width,
  input  logic [bb3_pkg::HEIGHT_W-1:0] image_height,
  bb3_res_if.source res
);
  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int RowW = bb3_pkg::ROW_W;
  localparam int PixW = bb3_pkg::PIX_W;
  localparam int SumW = bb3_pkg::SUM_W;
  localparam int CntW = bb3_pkg::CNT_W;
  localparam int ProdW = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;
  localparam int SW = RowW + 2;

  logic adv;
  logic [PixW-1:0] in_pix;
  logic [ColW-1:0] in_col;
  logic [RowW-1:0] in_row;

  // Line buffers: even rows in one bank, odd rows in the other.
  logic [PixW-1:0] bank0 [MAX_WIDTH];
  logic [PixW-1:0] bank1 [MAX_WIDTH];
  logic [PixW-1:0] rd0, rd1;

  logic            a_valid;
  logic [PixW-1:0] a_pix;
  logic [ColW-1:0] a_col;
  logic [RowW-1:0] a_row;

  logic [PixW-1:0] win_l [3];
  logic [PixW-1:0] win_c [3];

  logic [PixW-1:0] up, mid;
  logic            cz, lv, rvalid, emit, eof;
  logic [2:0]      rv;
  logic signed [SW-1:0] base, rr, hs;
  logic [PixW-1:0] px_grid [3][3];
  logic [2:0]      colv;
  logic [SumW-1:0] sums [3];
  logic [1:0]      nr, nc;
  logic [CntW-1:0] cnt;

  logic            b_valid;
  logic [SumW-1:0] b_sum [3];
  logic [CntW-1:0] b_cnt;
  logic            b_eof;

  logic [7:0]      quot [3];
  logic [SumW-1:0] num;
  logic [ProdW-1:0] prod;

  logic            o_valid;
  logic [7:0]      o_ch [3];
  logic            o_eof;

  // The whole back end moves when the result register is free or drained.
  assign adv    = !o_valid || res.ready;
  assign pop    = adv && !q_empty;
  assign in_pix = pop_data[ColW+RowW +: PixW];
  assign in_col = pop_data[RowW +: ColW];
  assign in_row = pop_data[RowW-1:0];

  // Each bank is read at the slot's column and written with the new pixel
  // when the slot's row has that bank's parity.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd0 <= bank0[in_col];
      if (!in_row[0]) begin
        bank0[in_col] <= in_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd1 <= bank1[in_col];
      if (in_row[0]) begin
        bank1[in_col] <= in_pix;
      end
    end
  end

  // Slot stage, aligned with the line buffer read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_pix <= in_pix;
      a_col <= in_col;
      a_row <= in_row;
    end
  end

  // Window columns, neighbor masks and per-channel sums.
  always_comb begin
    up     = a_row[0] ? rd1 : rd0;
    mid    = a_row[0] ? rd0 : rd1;
    cz     = (a_col == '0);
    hs     = $signed({2'b00, image_height});
    base   = $signed({2'b00, a_row}) - (cz ? SW'(3) : SW'(2));
    for (int i = 0; i < 3; i++) begin
      rr    = base + SW'(i);
      rv[i] = (rr >= 0) && (rr < hs);
    end
    lv      = cz ? (image_width >= WB'(2)) : (a_col >= ColW'(2));
    rvalid  = !cz;
    colv    = {rvalid, 1'b1, lv};
    emit    = rv[1];
    eof     = cz && (a_row == image_height + RowW'(1));
    for (int i = 0; i < 3; i++) begin
      px_grid[i][0] = win_l[i];
      px_grid[i][1] = win_c[i];
    end
    px_grid[0][2] = up;
    px_grid[1][2] = mid;
    px_grid[2][2] = a_pix;
    for (int k = 0; k < 3; k++) begin
      sums[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (rv[i] && colv[j]) begin
            sums[k] = sums[k] + SumW'(px_grid[i][j][PixW-1-8*k -: 8]);
          end
        end
      end
    end
    nr  = 2'(rv[0]) + 2'(rv[1]) + 2'(rv[2]);
    nc  = 2'(lv) + 2'd1 + 2'(rvalid);
    cnt = CntW'(nr) * CntW'(nc);
  end

  // Window shifts once per slot: rows are upper, middle, incoming.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_l[i] <= '0;
        win_c[i] <= '0;
      end
    end else if (adv && a_valid) begin
      for (int i = 0; i < 3; i++) begin
        win_l[i] <= win_c[i];
      end
      win_c[0] <= up;
      win_c[1] <= mid;
      win_c[2] <= a_pix;
    end
  end

  // Sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        b_sum[k] <= sums[k];
      end
      b_cnt <= cnt;
      b_eof <= eof;
    end
  end

  // Rounded mean: (sum + count/2) times the count's reciprocal.
  always_comb begin
    num  = '0;
    prod = '0;
    for (int k = 0; k < 3; k++) begin
      num     = b_sum[k] + SumW'(b_cnt >> 1);
      prod    = ProdW'(num) * ProdW'(bb3_pkg::recip(b_cnt));
      quot[k] = prod[bb3_pkg::RECIP_SHIFT +: 8];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        o_ch[k] <= quot[k];
      end
      o_eof <= b_eof;
    end
  end

  assign res.valid        = o_valid;
  assign res.blur_red     = o_ch[0];
  assign res.blur_green   = o_ch[1];
  assign res.blur_blue    = o_ch[2];
  assign res.end_of_frame = o_eof;
endmodule

>>> src/box_blur_3x3_rgb.sv
// Streaming 3x3 RGB box blur. Takes one word per cycle when not stalled; the
// result for pixel k of a frame passes the slot queue and the slot, sum and
// result registers after the word that completes its window, pixel k +
// image_width + 1 or a flush. A flush at the first column of a one-row
// frame's drain row runs an extra slot. Reset is synchronous: counters,
// window, pipeline clear, registers go to 640 by 480; line buffers do not.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bb3_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic clk,
  input  logic rst,
  bb3_pix_if.sink   pix,
  bb3_res_if.source res,
  bb3_cfg_if.sink   cfg
);
  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int SlotW = bb3_pkg::PIX_W + ColW + bb3_pkg::ROW_W;
  localparam int ResetWidth =
    (bb3_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : bb3_pkg::RESET_WIDTH;

  logic [WB-1:0] image_width, width_clamped;
  logic [bb3_pkg::HEIGHT_W-1:0] image_height, height_clamped;
  logic [bb3_pkg::WIDTH_FIELD_W-1:0] width_in;
  logic cfg_wr;
  logic q_full, q_empty, push, pop;
  logic [SlotW-1:0] push_data, pop_data;

  // Register writes are always taken; out-of-range values are clamped.
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;
  assign width_in  = cfg.data[bb3_pkg::WIDTH_FIELD_W-1:0];

  always_comb begin
    if (width_in == '0) begin
      width_clamped = WB'(1);
    end else if (32'(width_in) > 32'(MAX_WIDTH)) begin
      width_clamped = WB'(MAX_WIDTH);
    end else begin
      width_clamped = WB'(width_in);
    end
    if (cfg.data == '0) begin
      height_clamped = bb3_pkg::HEIGHT_W'(1);
    end else if (cfg.data > bb3_pkg::HEIGHT_LIMIT) begin
      height_clamped = bb3_pkg::HEIGHT_LIMIT;
    end else begin
      height_clamped = cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WB'(ResetWidth);
      image_height <= bb3_pkg::RESET_HEIGHT;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        bb3_pkg::REG_IMAGE_WIDTH:  image_width  <= width_clamped;
        bb3_pkg::REG_IMAGE_HEIGHT: image_height <= height_clamped;
        default: ;
      endcase
    end
  end

  // Front end: position tracking and slot generation.
  bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix),
    .restart      (cfg_wr),
    .image_width  (image_width),
    .image_height (image_height),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  // Slot queue between the two halves.
  bb3_queue #(.WIDTH(SlotW), .DEPTH(bb3_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Back end: line buffers, window and rounded means.
  bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .pop          (pop),
    .pop_data     (pop_data),
    .image_width  (image_width),
    .image_height (image_height),
    .res          (res)
  );
endmodule
